>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL; clk and arst_n come from the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)

`define ASSERT_IMPL(lbl, ante, cons, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/pias_pkg.sv
`default_nettype none

package pias_pkg;

	localparam int COORD_W  = 16;
	localparam int RADIUS_W = 16;
	localparam int ANGLE_W  = 13;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 16;

	localparam logic [CFG_AW-1:0] REG_CENTER_H    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_CENTER_V    = 3'd1;
	localparam logic [CFG_AW-1:0] REG_RADIUS      = 3'd2;
	localparam logic [CFG_AW-1:0] REG_START_ANGLE = 3'd3;
	localparam logic [CFG_AW-1:0] REG_STOP_ANGLE  = 3'd4;

	localparam int ANG_UNIT_BITS = 24;
	localparam int CORDIC_STEPS  = 26;
	localparam int CORDIC_SCALE  = 30;
	localparam int ZW            = 32;
	localparam int ANG_W         = 33;

	localparam logic signed [ZW-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
		32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
		32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
		32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
		32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
		32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
		32'sd917,       32'sd458,       32'sd229,       32'sd115,
		32'sd57,        32'sd29
	};

	localparam logic [ANG_W-1:0] ANG_90  = ANG_W'(90) << ANG_UNIT_BITS;
	localparam logic [ANG_W-1:0] ANG_180 = ANG_W'(180) << ANG_UNIT_BITS;
	localparam logic [ANG_W-1:0] ANG_360 = ANG_W'(360) << ANG_UNIT_BITS;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic outside;
		logic center;
		logic swap;
		logic hneg;
		logic vneg;
	} fl_t;

endpackage

`default_nettype wire

>>> rtl/pias_if.sv
`default_nettype none

interface pias_pix_if import pias_pkg::*;;
	logic   valid;
	logic   ready;
	coord_t pixel_h;
	coord_t pixel_v;

	modport source (output valid, output pixel_h, output pixel_v, input ready);
	modport sink (input valid, input pixel_h, input pixel_v, output ready);
endinterface

interface pias_res_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, output inside_res, input ready);
	modport sink (input valid, input inside_res, output ready);
endinterface

`default_nettype wire

>>> rtl/point_in_arc_sector_test.sv
`default_nettype none
`include "assert_macros.svh"

// Circular sector hit test. Each pixel request (pixel_h, pixel_v) returns one bit, set when
// the pixel is no farther from the configured center than the radius (exact integer test)
// and its clockwise angle, rounded to 1/2^ANGLE_FRAC_BITS degree, lies in the inclusive
// range start_angle..stop_angle, which wraps through zero when start is not below stop.
// The center pixel counts as 90 degrees. One pixel is accepted every clock while the skid
// entry is empty; a result passes three front stages, the 26-stage CORDIC angle pipeline
// and six back stages before the output register. A two-entry output (register plus skid)
// keeps requests flowing while a result waits. Write registers only while no request is
// in flight.
module point_in_arc_sector_test import pias_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 4,
	parameter int COORD_WIDTH = 16
) (
	input wire clk,
	input wire arst_n,
	input wire cfg_we,
	input wire [CFG_AW-1:0] cfg_addr,
	input wire [CFG_DW-1:0] cfg_wdata,
	pias_pix_if.sink pix,
	pias_res_if.source res
);

	localparam int CW = COORD_WIDTH;
	localparam int DW = CW + 1;
	localparam int PW = 2 * CW;
	localparam int XW = CW + 32;
	localparam int SH = ANG_UNIT_BITS - ANGLE_FRAC_BITS;
	localparam int KW = ANG_W - SH;
	localparam int MW = (KW > ANGLE_W) ? KW : ANGLE_W;
	localparam logic [ANG_W-1:0] ANG_HALF = ANG_W'(1) << (SH - 1);
	localparam logic [KW-1:0] FULL_K = KW'(360) << ANGLE_FRAC_BITS;

	coord_t center_h_q, center_v_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [ANGLE_W-1:0] start_q, stop_q;

	logic en;

	logic vld_s1, vld_s2, vld_s3;
	logic signed [DW-1:0] dh_s1, dv_s1;
	logic [CW-1:0] ax_s2, ay_s2;
	logic hneg_s2, vneg_s2;
	logic [PW-1:0] sqh_s3, sqv_s3, rsq_s3;
	logic [CW-1:0] big_s3, sml_s3;
	logic swp_s3, ctr_s3, hneg_s3, vneg_s3;
	logic [PW:0] dist_sum;
	fl_t fl_in0;

	logic [XW-1:0] cx_s [1:CORDIC_STEPS];
	logic [XW-1:0] cy_s [1:CORDIC_STEPS];
	logic cys_s [1:CORDIC_STEPS];
	logic signed [ZW-1:0] cz_s [1:CORDIC_STEPS];
	fl_t cf_s [1:CORDIC_STEPS];
	logic cv_s [1:CORDIC_STEPS];

	logic vld_s30, vld_s31, vld_s32, vld_s33, vld_s34, vld_s35;
	fl_t fl_s30, fl_s31, fl_s32, fl_s33, fl_s34;
	logic [ANG_W-1:0] zc_s30, ao_s31, ang_s32;
	logic [ANG_W-1:0] ang_rnd;
	logic [KW-1:0] kr_s33, k_s34;
	logic res_s35;

	logic out_vld_q, out_res_q, skd_vld_q, skd_res_q;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_h_q <= '0;
			center_v_q <= '0;
			radius_q <= '0;
			start_q <= '0;
			stop_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_CENTER_H: center_h_q <= coord_t'(cfg_wdata);
				REG_CENTER_V: center_v_q <= coord_t'(cfg_wdata);
				REG_RADIUS: radius_q <= cfg_wdata[RADIUS_W-1:0];
				REG_START_ANGLE: start_q <= cfg_wdata[ANGLE_W-1:0];
				REG_STOP_ANGLE: stop_q <= cfg_wdata[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	assign en = !skd_vld_q;
	assign pix.ready = en;

	// front stages: offsets, magnitudes, squares, octant swap and center flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pix.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dh_s1 <= signed'({pix.pixel_h[CW-1], pix.pixel_h[CW-1:0]})
				- signed'({center_h_q[CW-1], center_h_q[CW-1:0]});
			dv_s1 <= signed'({pix.pixel_v[CW-1], pix.pixel_v[CW-1:0]})
				- signed'({center_v_q[CW-1], center_v_q[CW-1:0]});

			ax_s2 <= CW'(dh_s1[DW-1] ? -dh_s1 : dh_s1);
			ay_s2 <= CW'(dv_s1[DW-1] ? -dv_s1 : dv_s1);
			hneg_s2 <= dh_s1[DW-1];
			vneg_s2 <= dv_s1[DW-1];

			sqh_s3 <= PW'(ax_s2) * PW'(ax_s2);
			sqv_s3 <= PW'(ay_s2) * PW'(ay_s2);
			rsq_s3 <= PW'(radius_q[CW-1:0]) * PW'(radius_q[CW-1:0]);
			swp_s3 <= ay_s2 > ax_s2;
			big_s3 <= (ay_s2 > ax_s2) ? ay_s2 : ax_s2;
			sml_s3 <= (ay_s2 > ax_s2) ? ax_s2 : ay_s2;
			ctr_s3 <= (ax_s2 == '0) && (ay_s2 == '0);
			hneg_s3 <= hneg_s2;
			vneg_s3 <= vneg_s2;
		end
	end

	always_comb begin
		dist_sum = {1'b0, sqh_s3} + {1'b0, sqv_s3};
		fl_in0.outside = dist_sum > {1'b0, rsq_s3};
		fl_in0.center = ctr_s3;
		fl_in0.swap = swp_s3;
		fl_in0.hneg = hneg_s3;
		fl_in0.vneg = vneg_s3;
	end

	// CORDIC vectoring, one step per stage; y kept as magnitude and sign
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_crd
		logic [XW-1:0] x_in, y_in, x_sh, y_sh;
		logic y_neg_in, v_in, live;
		logic signed [ZW-1:0] z_in;
		fl_t f_in;
		logic signed [XW:0] y_dif;

		if (i == 0) begin : g_first
			assign x_in = XW'(big_s3) << CORDIC_SCALE;
			assign y_in = XW'(sml_s3) << CORDIC_SCALE;
			assign y_neg_in = 1'b0;
			assign z_in = '0;
			assign f_in = fl_in0;
			assign v_in = vld_s3;
		end else begin : g_next
			assign x_in = cx_s[i];
			assign y_in = cy_s[i];
			assign y_neg_in = cys_s[i];
			assign z_in = cz_s[i];
			assign f_in = cf_s[i];
			assign v_in = cv_s[i];
		end

		assign x_sh = x_in >> i;
		assign y_sh = y_in >> i;
		assign y_dif = signed'({1'b0, y_in}) - signed'({1'b0, x_sh});
		assign live = (y_in != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else if (en) begin
				cv_s[i+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cf_s[i+1] <= f_in;
				if (live) begin
					cx_s[i+1] <= x_in + y_sh;
					if (!y_dif[XW]) begin
						cy_s[i+1] <= y_dif[XW-1:0];
						cys_s[i+1] <= y_neg_in;
					end else begin
						cy_s[i+1] <= x_sh - y_in;
						cys_s[i+1] <= !y_neg_in;
					end
					cz_s[i+1] <= y_neg_in ? z_in - ATAN_TAB[i] : z_in + ATAN_TAB[i];
				end else begin
					cx_s[i+1] <= x_in;
					cy_s[i+1] <= y_in;
					cys_s[i+1] <= y_neg_in;
					cz_s[i+1] <= z_in;
				end
			end
		end
	end

	// back stages: clamp, unfold, round, wrap, range test
	assign ang_rnd = ang_s32 + ANG_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s30 <= 1'b0;
			vld_s31 <= 1'b0;
			vld_s32 <= 1'b0;
			vld_s33 <= 1'b0;
			vld_s34 <= 1'b0;
			vld_s35 <= 1'b0;
		end else if (en) begin
			vld_s30 <= cv_s[CORDIC_STEPS];
			vld_s31 <= vld_s30;
			vld_s32 <= vld_s31;
			vld_s33 <= vld_s32;
			vld_s34 <= vld_s33;
			vld_s35 <= vld_s34;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s30 <= cf_s[CORDIC_STEPS];
			priority if (cz_s[CORDIC_STEPS] < 0) begin
				zc_s30 <= '0;
			end else if (cz_s[CORDIC_STEPS] > ATAN_TAB[0]) begin
				zc_s30 <= ANG_W'($unsigned(ATAN_TAB[0]));
			end else begin
				zc_s30 <= ANG_W'($unsigned(cz_s[CORDIC_STEPS]));
			end

			fl_s31 <= fl_s30;
			ao_s31 <= fl_s30.swap ? ANG_90 - zc_s30 : zc_s30;

			fl_s32 <= fl_s31;
			priority if (fl_s31.center) begin
				ang_s32 <= ANG_90;
			end else if (fl_s31.hneg && !fl_s31.vneg) begin
				ang_s32 <= ANG_180 - ao_s31;
			end else if (fl_s31.hneg) begin
				ang_s32 <= ANG_180 + ao_s31;
			end else if (fl_s31.vneg) begin
				ang_s32 <= ANG_360 - ao_s31;
			end else begin
				ang_s32 <= ao_s31;
			end

			fl_s33 <= fl_s32;
			kr_s33 <= ang_rnd[ANG_W-1:SH];

			fl_s34 <= fl_s33;
			k_s34 <= (kr_s33 >= FULL_K) ? kr_s33 - FULL_K : kr_s33;

			if (fl_s34.outside) begin
				res_s35 <= 1'b0;
			end else if (start_q < stop_q) begin
				res_s35 <= (MW'(start_q) <= MW'(k_s34)) && (MW'(k_s34) <= MW'(stop_q));
			end else begin
				res_s35 <= (MW'(start_q) <= MW'(k_s34)) || (MW'(k_s34) <= MW'(stop_q));
			end
		end
	end

	// output register with skid entry
	assign take = vld_s35 && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_res_q <= 1'b0;
			skd_vld_q <= 1'b0;
			skd_res_q <= 1'b0;
		end else if (skd_vld_q) begin
			if (res.ready) begin
				out_res_q <= skd_res_q;
				skd_vld_q <= 1'b0;
			end
		end else if (take) begin
			if (!out_vld_q || res.ready) begin
				out_vld_q <= 1'b1;
				out_res_q <= res_s35;
			end else begin
				skd_vld_q <= 1'b1;
				skd_res_q <= res_s35;
			end
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign res.valid = out_vld_q;
	assign res.inside_res = out_res_q;

	`ASSERT_IMPL(a_skid_has_out, skd_vld_q, out_vld_q, "skid entry held with empty output")
	`ASSERT_IMPL(a_skid_fill, skd_vld_q && !$past(skd_vld_q), $past(out_vld_q) && !$past(res.ready), "skid filled while output was free")
	`ASSERT_NEXT(a_stall_hold, !en, $stable(vld_s35) && $stable(res_s35), "pipeline moved during stall")

endmodule

`default_nettype wire

>>> bench/point_in_arc_sector_test_test.sv
`timescale 1ns / 1ps

module point_in_arc_sector_test_test;
	import pias_pkg::*;

	typedef enum logic [1:0] {REQ_PIXEL, REQ_WRITE, REQ_DRAIN} req_kind_e;

	typedef struct {
		req_kind_e kind;
		coord_t h;
		coord_t v;
		logic [CFG_AW-1:0] addr;
		logic [CFG_DW-1:0] data;
	} sector_req_t;

	localparam logic [CFG_AW-1:0] REG_NONE = 3'd7;
	localparam int FRAC_BITS = 4;
	localparam int ARC_STEPS = 26;
	localparam longint ONE_DEG = 64'sd1 << 24;
	localparam int ROUND_SHIFT = 24 - FRAC_BITS;
	localparam longint ROUND_HALF = 64'sd1 << (ROUND_SHIFT - 1);
	localparam longint FULL_TURN = 64'sd360 << FRAC_BITS;
	localparam longint ARCTAN_STEP [ARC_STEPS] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
		117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
		115, 57, 29
	};
	localparam int QUIET_LIMIT = 4000;
	localparam int LONG_HOLD_AT = 400;
	localparam int LONG_HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic px_valid = 1'b0;
	coord_t px_h = '0;
	coord_t px_v = '0;
	logic rx_ready = 1'b0;

	pias_pix_if pix();
	pias_res_if res();

	assign pix.valid = px_valid;
	assign pix.pixel_h = px_h;
	assign pix.pixel_v = px_v;
	assign res.ready = rx_ready;

	point_in_arc_sector_test u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.pix(pix),
		.res(res)
	);

	always #10 clk = ~clk;

	sector_req_t pixel_reqs[$];
	logic inside_expected[$];
	int pending_results = 0;
	int accepted_cnt = 0;
	int errors = 0;

	coord_t sec_center_h;
	coord_t sec_center_v;
	logic [RADIUS_W-1:0] sec_radius;
	logic [ANGLE_W-1:0] sec_start;
	logic [ANGLE_W-1:0] sec_stop;

	int gap_left = 0;
	int send_burst_left = 0;
	logic send_calm = 1'b0;
	int stall_left = 0;
	int rx_calm_left = 0;
	logic long_hold_done = 1'b0;
	int quiet_cycles = 0;

	function automatic longint shift_tz(longint val, int sh);
		if (val < 0)
			return -((-val) >> sh);
		return val >> sh;
	endfunction

	function automatic longint octant_angle(longint ax, longint ay);
		longint x, y, z, nx;
		x = ax << 30;
		y = ay << 30;
		z = 0;
		for (int i = 0; i < ARC_STEPS; i++) begin
			if (y == 0)
				break;
			if (y > 0) begin
				nx = x + shift_tz(y, i);
				y = y - shift_tz(x, i);
				z = z + ARCTAN_STEP[i];
			end else begin
				nx = x - shift_tz(y, i);
				y = y + shift_tz(x, i);
				z = z - ARCTAN_STEP[i];
			end
			x = nx;
		end
		if (z < 0)
			z = 0;
		if (z > ARCTAN_STEP[0])
			z = ARCTAN_STEP[0];
		return z;
	endfunction

	function automatic logic sector_hit(coord_t ph, coord_t pv);
		longint dh, dv, ax, ay, a, k;
		longint unsigned dist2, r2;
		dh = longint'(ph) - longint'(sec_center_h);
		dv = longint'(pv) - longint'(sec_center_v);
		ax = dh < 0 ? -dh : dh;
		ay = dv < 0 ? -dv : dv;
		dist2 = longint'(ax * ax) + longint'(ay * ay);
		r2 = longint'(sec_radius) * longint'(sec_radius);
		if (dist2 > r2)
			return 1'b0;
		if (ax == 0 && ay == 0) begin
			a = 90 * ONE_DEG;
		end else begin
			if (ay > ax)
				a = 90 * ONE_DEG - octant_angle(ay, ax);
			else
				a = octant_angle(ax, ay);
			if (dh < 0 && dv >= 0)
				a = 180 * ONE_DEG - a;
			else if (dh < 0)
				a = 180 * ONE_DEG + a;
			else if (dv < 0)
				a = 360 * ONE_DEG - a;
		end
		k = (a + ROUND_HALF) >> ROUND_SHIFT;
		if (k >= FULL_TURN)
			k = k - FULL_TURN;
		if (sec_start < sec_stop)
			return k >= longint'(sec_start) && k <= longint'(sec_stop);
		return k >= longint'(sec_start) || k <= longint'(sec_stop);
	endfunction

	function automatic int pick_gap();
		int roll;
		if (send_burst_left == 0) begin
			send_calm = $urandom_range(0, 3) == 0;
			send_burst_left = send_calm ? $urandom_range(50, 150) : $urandom_range(20, 80);
		end
		send_burst_left--;
		if (send_calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_pixel(coord_t h, coord_t v);
		sector_req_t r;
		r.kind = REQ_PIXEL;
		r.h = h;
		r.v = v;
		r.addr = REG_NONE;
		r.data = '0;
		pixel_reqs.push_back(r);
	endtask

	task automatic add_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
		sector_req_t r;
		r.kind = REQ_WRITE;
		r.h = '0;
		r.v = '0;
		r.addr = addr;
		r.data = data;
		pixel_reqs.push_back(r);
	endtask

	task automatic add_drain();
		sector_req_t r;
		r.kind = REQ_DRAIN;
		r.h = '0;
		r.v = '0;
		r.addr = REG_NONE;
		r.data = '0;
		pixel_reqs.push_back(r);
	endtask

	task automatic add_config(coord_t ch, coord_t cv, int r, int s, int e);
		add_write(REG_CENTER_H, CFG_DW'(ch));
		add_write(REG_CENTER_V, CFG_DW'(cv));
		add_write(REG_RADIUS, CFG_DW'(r));
		add_write(REG_START_ANGLE, CFG_DW'(s));
		add_write(REG_STOP_ANGLE, CFG_DW'(e));
	endtask

	task automatic add_random_config(output coord_t ch, output coord_t cv, output int r);
		int roll, s, e;
		roll = $urandom_range(0, 9);
		ch = roll == 0 ? -16'sd32768 : roll == 1 ? 16'sd32767 : coord_t'($urandom);
		roll = $urandom_range(0, 9);
		cv = roll == 0 ? -16'sd32768 : roll == 1 ? 16'sd32767 : coord_t'($urandom);
		roll = $urandom_range(0, 9);
		if (roll == 0)
			r = 0;
		else if (roll == 1)
			r = 65535;
		else if (roll < 4)
			r = $urandom_range(1, 15);
		else if (roll < 6)
			r = $urandom_range(16, 1000);
		else
			r = $urandom_range(0, 65535);
		roll = $urandom_range(0, 9);
		s = $urandom_range(0, 5759);
		e = $urandom_range(0, 5759);
		if (roll == 0) begin
			s = 0;
			e = 5759;
		end else if (roll == 1) begin
			e = s;
		end else if (roll == 2) begin
			s = $urandom_range(5760, 8191);
			e = $urandom_range(0, 8191);
		end else if (roll == 3) begin
			s = 5759;
			e = 0;
		end
		add_config(ch, cv, r, s, e);
	endtask

	task automatic add_random_pixel(coord_t ch, coord_t cv, int r);
		int rr, oh, ov, roll, m, sh, sv;
		rr = r + r / 8 + 2;
		sh = $urandom_range(0, 1) ? 1 : -1;
		sv = $urandom_range(0, 1) ? 1 : -1;
		roll = $urandom_range(0, 99);
		if (roll < 65) begin
			oh = int'($urandom_range(0, 2 * rr)) - rr;
			ov = int'($urandom_range(0, 2 * rr)) - rr;
		end else if (roll < 75) begin
			case ($urandom_range(0, 2))
			0: m = r;
			1: m = r + 1;
			default: m = $urandom_range(0, rr);
			endcase
			if ($urandom_range(0, 1)) begin
				oh = sh * m;
				ov = 0;
			end else begin
				oh = 0;
				ov = sv * m;
			end
		end else if (roll < 82) begin
			m = $urandom_range(0, rr);
			oh = sh * m;
			ov = sv * m;
		end else begin
			add_pixel(coord_t'($urandom), coord_t'($urandom));
			return;
		end
		add_pixel(coord_t'(ch + oh), coord_t'(cv + ov));
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_valid <= 1'b0;
			cfg_we <= 1'b0;
			gap_left = 0;
		end else begin
			logic next_valid, next_we, idle;
			sector_req_t head;
			next_we = 1'b0;
			next_valid = px_valid && !pix.ready;
			idle = !px_valid && pending_results == 0;
			if (!next_valid) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (pixel_reqs.size() != 0) begin
					head = pixel_reqs[0];
					case (head.kind)
					REQ_PIXEL: begin
						void'(pixel_reqs.pop_front());
						next_valid = 1'b1;
						px_h <= head.h;
						px_v <= head.v;
						gap_left = pick_gap();
					end
					REQ_WRITE: if (idle) begin
						void'(pixel_reqs.pop_front());
						next_we = 1'b1;
						cfg_addr <= head.addr;
						cfg_wdata <= head.data;
					end
					default: if (idle)
						void'(pixel_reqs.pop_front());
					endcase
				end
			end
			px_valid <= next_valid;
			cfg_we <= next_we;
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ready <= 1'b0;
			stall_left = 0;
			rx_calm_left = 0;
		end else begin
			logic next_ready;
			int roll;
			next_ready = 1'b1;
			if (!long_hold_done && accepted_cnt >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD_CYCLES;
			end
			if (stall_left != 0) begin
				stall_left--;
				next_ready = 1'b0;
			end else if (rx_calm_left != 0) begin
				rx_calm_left--;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 23) begin
					stall_left = $urandom_range(0, 2);
					next_ready = 1'b0;
				end else if (roll < 25) begin
					stall_left = $urandom_range(10, 60);
					next_ready = 1'b0;
				end else if (roll < 28) begin
					rx_calm_left = $urandom_range(50, 200);
				end
			end
			rx_ready <= next_ready;
		end
	end

	// config shadow, prediction and result check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_center_h = '0;
			sec_center_v = '0;
			sec_radius = '0;
			sec_start = '0;
			sec_stop = '0;
			inside_expected.delete();
			pending_results <= 0;
			accepted_cnt <= 0;
		end else begin
			logic want;
			if (cfg_we) begin
				case (cfg_addr)
				REG_CENTER_H: sec_center_h = coord_t'(cfg_wdata);
				REG_CENTER_V: sec_center_v = coord_t'(cfg_wdata);
				REG_RADIUS: sec_radius = cfg_wdata[RADIUS_W-1:0];
				REG_START_ANGLE: sec_start = cfg_wdata[ANGLE_W-1:0];
				REG_STOP_ANGLE: sec_stop = cfg_wdata[ANGLE_W-1:0];
				default: ;
				endcase
			end
			if (pix.valid && pix.ready) begin
				inside_expected.push_back(sector_hit(pix.pixel_h, pix.pixel_v));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (res.valid && res.ready) begin
				if (inside_expected.size() == 0) begin
					$error("inside_res: unexpected result %0b with nothing expected",
						res.inside_res);
					errors++;
				end else begin
					want = inside_expected.pop_front();
					if (res.inside_res !== want) begin
						$error("inside_res mismatch: expected %0b, actual %0b",
							want, res.inside_res);
						errors++;
					end
				end
			end
			pending_results <= inside_expected.size();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix.valid && pix.ready) || (res.valid && res.ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL point_in_arc_sector_test");
				$finish;
			end
		end
	end

	initial begin
		coord_t ch, cv;
		int r;

		// reset values: only the center is inside, any angle passes
		add_pixel(16'sd0, 16'sd0);
		add_pixel(16'sd1, 16'sd0);

		add_config(16'sd0, 16'sd0, 65535, 0, 5759);
		add_pixel(16'sd32767, 16'sd32767);
		add_pixel(-16'sd32768, -16'sd32768);
		add_pixel(16'sd32767, -16'sd32768);
		add_pixel(-16'sd32768, 16'sd0);
		add_pixel(16'sd0, 16'sd0);
		add_pixel(16'sd100, 16'sd0);
		add_pixel(16'sd0, 16'sd100);
		add_pixel(16'sd0, -16'sd100);
		add_pixel(-16'sd100, -16'sd100);
		add_pixel(16'sd3, -16'sd4);

		// wrapped range, radius boundary at full span
		add_config(-16'sd32768, 16'sd32767, 65535, 5000, 1000);
		add_pixel(16'sd32767, 16'sd32767);
		add_pixel(16'sd32767, 16'sd32766);
		add_pixel(-16'sd32768, -16'sd32768);
		add_pixel(16'sd0, 16'sd0);

		add_config(16'sd0, 16'sd0, 1000, 1440, 1440);
		add_pixel(16'sd0, 16'sd10);
		add_pixel(-16'sd10, 16'sd0);

		// start above the normalized range
		add_config(16'sd0, 16'sd0, 1000, 8191, 1440);
		add_write(REG_NONE, 16'hFFFF);
		add_pixel(16'sd0, 16'sd10);
		add_pixel(-16'sd10, 16'sd0);

		for (int p = 0; p < 12; p++) begin
			add_random_config(ch, cv, r);
			for (int n = 0; n < 154; n++) begin
				if (p == 5 && n == 77)
					add_drain();
				add_random_pixel(ch, cv, r);
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do
			@(negedge clk);
		while (pixel_reqs.size() != 0 || px_valid || pending_results != 0);
		repeat (60) @(posedge clk);

		if (errors == 0 && inside_expected.size() == 0)
			$display("PASS point_in_arc_sector_test");
		else
			$display("FAIL point_in_arc_sector_test");
		$finish;
	end

endmodule
